/* rtl/glc_pkg.sv */
package glc_pkg;

    localparam int CODE_W     = 16;
    localparam int FONT_W     = 16;
    localparam int KEY_W      = CODE_W + FONT_W;
    localparam int SLOT_OUT_W = 6;
    localparam int METRIC_W   = 5;
    localparam int ROWB_W     = 2;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    localparam logic [CODE_W-1:0]   NARROW_LIMIT  = 16'd128;
    localparam logic [METRIC_W-1:0] NARROW_WIDTH  = 5'd8;
    localparam logic [METRIC_W-1:0] WIDE_WIDTH    = 5'd16;
    localparam logic [METRIC_W-1:0] GLYPH_HEIGHT  = 5'd16;
    localparam logic [ROWB_W-1:0]   NARROW_ROWB   = 2'd1;
    localparam logic [ROWB_W-1:0]   WIDE_ROWB     = 2'd2;

    typedef logic [S_DATA_W-1:0] s_data_t;
    typedef logic [M_DATA_W-1:0] m_data_t;

endpackage

/* rtl/glyph_cache_lru_lookup.sv */
// A request word is accepted only in the idle state. The scan then reads one slot of the
// key/stamp memory per cycle, the drain state finishes the compare of the last slot read,
// and the write-back state updates the chosen slot, waiting while the output register
// still holds an untaken result. A finished result waits in the output register while the next request is scanned.
// Reset (aresetn low at a clock edge) clears all slot valid bits, the use counter and
// the handshake state; the key/stamp memory is not cleared.
module glyph_cache_lru_lookup #(
    parameter int ENTRIES    = 48,
    parameter int STAMP_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  glc_pkg::s_data_t  s_tdata,   // [15:0] char_code, [31:16] font_id
    output logic              m_tvalid,
    input  logic              m_tready,
    output glc_pkg::m_data_t  m_tdata    // [5:0] slot_index, [6] hit, [7] evicted,
                                         // [12:8] glyph_width, [17:13] glyph_height,
                                         // [19:18] bytes_per_row, [23:20] zero
);
    import glc_pkg::*;

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MEM_W = KEY_W + STAMP_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    logic [MEM_W-1:0] mem [ENTRIES];
    logic [MEM_W-1:0] rd_data_reg;

    logic [ENTRIES-1:0]    valid_reg;
    logic [1:0]            state_reg, state_next;
    logic [STAMP_BITS-1:0] use_counter_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [IW-1:0]         scan_idx_reg;

    logic                  chk_pend_reg;
    logic                  chk_vbit_reg;
    logic [IW-1:0]         chk_idx_reg;

    logic                  hit_found_reg;
    logic [IW-1:0]         hit_idx_reg;
    logic                  free_found_reg;
    logic [IW-1:0]         free_idx_reg;
    logic                  vic_found_reg;
    logic [IW-1:0]         vic_idx_reg;
    logic [STAMP_BITS-1:0] vic_stamp_reg;

    logic                  m_tvalid_reg;
    m_data_t               m_tdata_reg;

    logic                  s_accept;
    logic                  out_free;
    logic [KEY_W-1:0]      rd_key;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [IW-1:0]         slot;
    logic [IW+SLOT_OUT_W-1:0] slot_ext;
    logic                  narrow;
    m_data_t               result;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_key   = rd_data_reg[MEM_W-1:STAMP_BITS];
    assign rd_stamp = rd_data_reg[STAMP_BITS-1:0];

    // Priority: a matching key, then the lowest free slot, then the oldest stamp.
    assign slot = hit_found_reg  ? hit_idx_reg  :
                  free_found_reg ? free_idx_reg : vic_idx_reg;

    assign slot_ext = (IW + SLOT_OUT_W)'(slot);
    assign narrow   = (key_reg[KEY_W-1:FONT_W] < NARROW_LIMIT);

    always_comb begin
        result        = '0;
        result[5:0]   = slot_ext[SLOT_OUT_W-1:0];
        result[6]     = hit_found_reg;
        result[7]     = !hit_found_reg && !free_found_reg;
        result[12:8]  = narrow ? NARROW_WIDTH : WIDE_WIDTH;
        result[17:13] = GLYPH_HEIGHT;
        result[19:18] = narrow ? NARROW_ROWB : WIDE_ROWB;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Key/stamp memory: one read port for the scan, one write port for the update.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
        if (state_reg == ST_WRITE) begin
            mem[slot] <= {key_reg, use_counter_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            use_counter_reg <= '0;
            chk_pend_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chk_pend_reg <= (state_reg == ST_SCAN);
            if (s_accept) begin
                use_counter_reg <= use_counter_reg + 1'b1;
            end
            if (state_reg == ST_WRITE) begin
                valid_reg[slot] <= 1'b1;
            end
            if (state_reg == ST_WRITE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg        <= {s_tdata[CODE_W-1:0], s_tdata[KEY_W-1:CODE_W]};
            scan_idx_reg   <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end
        if (state_reg == ST_SCAN) begin
            chk_idx_reg  <= scan_idx_reg;
            chk_vbit_reg <= valid_reg[scan_idx_reg];
            if (scan_idx_reg != LAST_IDX) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
        if (chk_pend_reg) begin
            if (chk_vbit_reg && rd_key == key_reg && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= chk_idx_reg;
            end
            if (!chk_vbit_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= chk_idx_reg;
            end
            // Strict compare keeps the lowest index on equal stamps.
            if (chk_vbit_reg && (!vic_found_reg || rd_stamp < vic_stamp_reg)) begin
                vic_found_reg <= 1'b1;
                vic_idx_reg   <= chk_idx_reg;
                vic_stamp_reg <= rd_stamp;
            end
        end
        if (state_reg == ST_WRITE && out_free) begin
            m_tdata_reg <= result;
        end
    end

    a_hit_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && hit_found_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit slot is not valid");

    // Checked on the first write-back cycle only; a stalled write-back has already set it.
    a_free_slot_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && $past(state_reg) == ST_DRAIN
            && !hit_found_reg && free_found_reg)
            |-> !valid_reg[free_idx_reg])
        else $error("free slot is already valid");

    a_evict_has_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && !hit_found_reg && !free_found_reg)
            |-> (vic_found_reg && (&valid_reg)))
        else $error("eviction without a full table");

    a_slot_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |=> valid_reg[$past(slot)])
        else $error("written slot not marked valid");

    a_counter_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(use_counter_reg))
        else $error("use counter moved without a request");

endmodule
